/* sv/rmq_pkg.sv */
`default_nettype none
package rmq_pkg;

   localparam int WORD_WIDTH = 20;
   localparam int FRAC_BITS  = 16;

   // trace sum, its positive part, root operand and root widths
   localparam int SUM_W  = WORD_WIDTH + 2;
   localparam int POS_W  = SUM_W - 1;
   localparam int OPD_B  = POS_W + FRAC_BITS;
   localparam int ROOT_W = (OPD_B + 1) / 2;
   localparam int OPD_W  = 2 * ROOT_W;
   // off-diagonal magnitude, scaled numerator and divider remainder widths
   localparam int MAG_W  = WORD_WIDTH + 1;
   localparam int NUM_W  = MAG_W + FRAC_BITS;
   localparam int REM_W  = NUM_W + ROOT_W;

   localparam logic [1:0] SEL_W = 2'd0;
   localparam logic [1:0] SEL_X = 2'd1;
   localparam logic [1:0] SEL_Y = 2'd2;
   localparam logic [1:0] SEL_Z = 2'd3;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] m00;
      logic signed [WORD_WIDTH-1:0] m11;
      logic signed [WORD_WIDTH-1:0] m22;
      logic signed [WORD_WIDTH-1:0] m33;
      logic signed [WORD_WIDTH-1:0] m01;
      logic signed [WORD_WIDTH-1:0] m10;
      logic signed [WORD_WIDTH-1:0] m02;
      logic signed [WORD_WIDTH-1:0] m20;
      logic signed [WORD_WIDTH-1:0] m12;
      logic signed [WORD_WIDTH-1:0] m21;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] quat_w;
      logic signed [WORD_WIDTH-1:0] quat_x;
      logic signed [WORD_WIDTH-1:0] quat_y;
      logic signed [WORD_WIDTH-1:0] quat_z;
      logic                         degenerate;
   } rsp_type;

   // per-item control that rides along the pipeline
   typedef struct packed {
      logic [1:0]             sel;
      logic                   deg;
      logic [2:0]             neg;
      logic [2:0][MAG_W-1:0]  mag;
   } carry_type;

endpackage
`default_nettype wire

/* sv/rotation_matrix_to_quaternion_top.sv */
// rotation matrix to quaternion, fixed point (16 fraction bits, 20-bit words)
//
// input: drive req_data and raise start; a beat is taken on every edge where
// start is high and busy is low. busy is always low: a new matrix can enter
// every cycle, so the sustained rate is one item per clock.
// output: rsp_valid strobes for one cycle with rsp_data; the receiver has no
// way to stall, results come out in input order.
// pipeline, in order from the accepting edge to the result register:
// one stage for trace sums and selection, 19 stages of the bit-per-stage
// square root, one saturation check stage, 20 stages of the three parallel
// bit-per-stage dividers and one output stage for rounding and clamping.
// a largest trace sum that is not positive gives zero components and sets
// degenerate.
// reset (synchronous, active high) clears all valid bits; items in flight
// are dropped and no strobe follows until new beats come in.
`default_nettype none
module rotation_matrix_to_quaternion_top
   import rmq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int W = WORD_WIDTH;
   localparam int F = FRAC_BITS;

   assign busy = 1'b0;

   // ---------------- stage 1: trace sums, selection, differences
   logic signed [SUM_W-1:0] s_w, s_x, s_y, s_z, best_a, best_b, best;
   logic [1:0]              sel_a, sel_b, sel;
   logic signed [MAG_W-1:0] d_12m21, d_20m02, d_01m10, d_01p10, d_02p20, d_12p21;
   logic signed [MAG_W-1:0] dl [3];
   carry_type               s1_carry_in;
   logic [OPD_W-1:0]        s1_opd_in;

   always_comb begin
      s_w = SUM_W'(req_data.m00) + SUM_W'(req_data.m11) + SUM_W'(req_data.m22)
            + SUM_W'(req_data.m33);
      s_x = SUM_W'(req_data.m00) - SUM_W'(req_data.m11) - SUM_W'(req_data.m22)
            + SUM_W'(req_data.m33);
      s_y = -SUM_W'(req_data.m00) + SUM_W'(req_data.m11) - SUM_W'(req_data.m22)
            + SUM_W'(req_data.m33);
      s_z = -SUM_W'(req_data.m00) - SUM_W'(req_data.m11) + SUM_W'(req_data.m22)
            + SUM_W'(req_data.m33);
      best_a = s_w;
      sel_a  = SEL_W;
      if (s_x > best_a) begin
         best_a = s_x;
         sel_a  = SEL_X;
      end
      best_b = best_a;
      sel_b  = sel_a;
      if (s_y > best_b) begin
         best_b = s_y;
         sel_b  = SEL_Y;
      end
      best = best_b;
      sel  = sel_b;
      if (s_z > best) begin
         best = s_z;
         sel  = SEL_Z;
      end

      d_12m21 = MAG_W'(req_data.m12) - MAG_W'(req_data.m21);
      d_20m02 = MAG_W'(req_data.m20) - MAG_W'(req_data.m02);
      d_01m10 = MAG_W'(req_data.m01) - MAG_W'(req_data.m10);
      d_01p10 = MAG_W'(req_data.m01) + MAG_W'(req_data.m10);
      d_02p20 = MAG_W'(req_data.m02) + MAG_W'(req_data.m20);
      d_12p21 = MAG_W'(req_data.m12) + MAG_W'(req_data.m21);

      case (sel)
         SEL_W: begin
            dl[0] = d_12m21; dl[1] = d_20m02; dl[2] = d_01m10;
         end
         SEL_X: begin
            dl[0] = d_12m21; dl[1] = d_01p10; dl[2] = d_02p20;
         end
         SEL_Y: begin
            dl[0] = d_20m02; dl[1] = d_01p10; dl[2] = d_12p21;
         end
         default: begin
            dl[0] = d_01m10; dl[1] = d_02p20; dl[2] = d_12p21;
         end
      endcase

      s1_carry_in.sel = sel;
      s1_carry_in.deg = (best <= 0);
      for (int l = 0; l < 3; l++) begin
         s1_carry_in.neg[l] = dl[l][MAG_W-1];
         s1_carry_in.mag[l] = dl[l][MAG_W-1] ? MAG_W'(-dl[l]) : MAG_W'(dl[l]);
      end
      s1_opd_in = s1_carry_in.deg ? '0
                  : OPD_W'({best[POS_W-1:0], {F{1'b0}}});
   end

   // ---------------- square root, one result bit per stage
   // index 0 holds the stage 1 registers
   logic                    sq_vld_ff  [ROOT_W+1];
   carry_type               sq_carry_ff[ROOT_W+1];
   logic [OPD_W-1:0]        sq_opd_ff  [ROOT_W+1];
   logic [ROOT_W+1:0]       sq_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]       sq_root_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= start;
      end
      sq_carry_ff[0] <= s1_carry_in;
      sq_opd_ff[0]   <= s1_opd_in;
      sq_rem_ff[0]   <= '0;
      sq_root_ff[0]  <= '0;
   end

   for (genvar j = 1; j <= ROOT_W; j++) begin : g_sqrt
      logic [ROOT_W+1:0] rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         rem_sh = {sq_rem_ff[j-1][ROOT_W-1:0], sq_opd_ff[j-1][OPD_W-1 -: 2]};
         trial  = {sq_root_ff[j-1], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {sq_root_ff[j-1][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {sq_root_ff[j-1][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j] <= 1'b0;
         end else begin
            sq_vld_ff[j] <= sq_vld_ff[j-1];
         end
         sq_carry_ff[j] <= sq_carry_ff[j-1];
         sq_opd_ff[j]   <= {sq_opd_ff[j-1][OPD_W-3:0], 2'b00};
         sq_rem_ff[j]   <= rem_in;
         sq_root_ff[j]  <= root_in;
      end
   end

   // ---------------- saturation check and dividers, one quotient bit per stage
   // index 0 holds the saturation check stage
   logic              dv_vld_ff  [W+1];
   carry_type         dv_carry_ff[W+1];
   logic [ROOT_W-1:0] dv_root_ff [W+1];
   logic [2:0]        dv_sat_ff  [W+1];
   logic [REM_W-1:0]  dv_rem_ff  [W+1][3];
   logic [W-1:0]      dv_q_ff    [W+1][3];

   logic [REM_W-1:0]  sat_lim;
   assign sat_lim = REM_W'({sq_root_ff[ROOT_W], {W{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[ROOT_W];
      end
      dv_carry_ff[0] <= sq_carry_ff[ROOT_W];
      dv_root_ff[0]  <= sq_root_ff[ROOT_W];
      for (int l = 0; l < 3; l++) begin
         dv_rem_ff[0][l] <= REM_W'({sq_carry_ff[ROOT_W].mag[l], {F{1'b0}}});
         dv_q_ff[0][l]   <= '0;
         dv_sat_ff[0][l] <= REM_W'({sq_carry_ff[ROOT_W].mag[l], {F{1'b0}}}) >= sat_lim;
      end
   end

   for (genvar d = 1; d <= W; d++) begin : g_div
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] rem_in [3];
      logic [W-1:0]     q_in   [3];

      assign trial = REM_W'(dv_root_ff[d-1]) << (W - d);

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (dv_rem_ff[d-1][l] >= trial) begin
               rem_in[l] = dv_rem_ff[d-1][l] - trial;
               q_in[l]   = {dv_q_ff[d-1][l][W-2:0], 1'b1};
            end else begin
               rem_in[l] = dv_rem_ff[d-1][l];
               q_in[l]   = {dv_q_ff[d-1][l][W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[d] <= 1'b0;
         end else begin
            dv_vld_ff[d] <= dv_vld_ff[d-1];
         end
         dv_carry_ff[d] <= dv_carry_ff[d-1];
         dv_root_ff[d]  <= dv_root_ff[d-1];
         dv_sat_ff[d]   <= dv_sat_ff[d-1];
         for (int l = 0; l < 3; l++) begin
            dv_rem_ff[d][l] <= rem_in[l];
            dv_q_ff[d][l]   <= q_in[l];
         end
      end
   end

   // ---------------- output: rounding, clamping, slot mapping
   localparam logic [W:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
   localparam logic [W:0] NEG_LIM = {2'b01, {(W-1){1'b0}}};

   carry_type         oc;
   logic [ROOT_W:0]   main_h;
   logic [W-1:0]      main_v;
   logic [W:0]        half, lim;
   logic [W-1:0]      lane_v [3];
   rsp_type           rsp_in;
   logic              rsp_valid_in;

   always_comb begin
      oc     = dv_carry_ff[W];
      main_h = ({1'b0, dv_root_ff[W]} + 1'b1) >> 1;
      main_v = (main_h > (ROOT_W+1)'(POS_LIM)) ? POS_LIM[W-1:0] : W'(main_h);
      for (int l = 0; l < 3; l++) begin
         half = ({1'b0, dv_q_ff[W][l]} + 1'b1) >> 1;
         lim  = oc.neg[l] ? NEG_LIM : POS_LIM;
         if (dv_sat_ff[W][l] || half > lim) begin
            half = lim;
         end
         lane_v[l] = oc.neg[l] ? W'(~half + 1'b1) : half[W-1:0];
      end

      case (oc.sel)
         SEL_W: begin
            rsp_in.quat_w = main_v;    rsp_in.quat_x = lane_v[0];
            rsp_in.quat_y = lane_v[1]; rsp_in.quat_z = lane_v[2];
         end
         SEL_X: begin
            rsp_in.quat_w = lane_v[0]; rsp_in.quat_x = main_v;
            rsp_in.quat_y = lane_v[1]; rsp_in.quat_z = lane_v[2];
         end
         SEL_Y: begin
            rsp_in.quat_w = lane_v[0]; rsp_in.quat_x = lane_v[1];
            rsp_in.quat_y = main_v;    rsp_in.quat_z = lane_v[2];
         end
         default: begin
            rsp_in.quat_w = lane_v[0]; rsp_in.quat_x = lane_v[1];
            rsp_in.quat_y = lane_v[2]; rsp_in.quat_z = main_v;
         end
      endcase
      rsp_in.degenerate = oc.deg;
      if (oc.deg) begin
         rsp_in.quat_w = '0;
         rsp_in.quat_x = '0;
         rsp_in.quat_y = '0;
         rsp_in.quat_z = '0;
      end
      rsp_valid_in = dv_vld_ff[W];
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* test/tb_rotation_matrix_to_quaternion_top.sv */
`default_nettype none
module tb_rotation_matrix_to_quaternion_top;
   import rmq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 42;
   localparam longint POS_LIM = (64'sd1 <<< (WORD_WIDTH - 1)) - 1;
   localparam longint NEG_LIM = 64'sd1 <<< (WORD_WIDTH - 1);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rotation_matrix_to_quaternion_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   typedef struct {
      req_type matrix;
      logic    has_quat;
      rsp_type quat;
   } vector_type;

   rsp_type pending_quats[$];
   int      error_count = 0;
   int      send_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // floor(sqrt(s * 2^FRAC_BITS))
   function automatic longint unsigned fixed_sqrt(longint unsigned s);
      longint unsigned opd;
      longint unsigned root;
      longint unsigned bitv;
      opd  = s << FRAC_BITS;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > opd) bitv >>= 2;
      while (bitv != 0) begin
         if (opd >= root + bitv) begin
            opd  -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] scaled_part(longint d, longint unsigned r);
      logic            neg;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned cap;
      neg = d < 0;
      mag = neg ? -d : d;
      cap = 64'd1 << WORD_WIDTH;
      q = (mag << FRAC_BITS) / r;
      if (q > cap) q = cap;
      q = (q + 1) >> 1;
      if (neg) begin
         if (q > NEG_LIM) q = NEG_LIM;
         return WORD_WIDTH'(-longint'(q));
      end
      if (q > POS_LIM) q = POS_LIM;
      return WORD_WIDTH'(q);
   endfunction

   function automatic rsp_type matrix_to_quat(req_type m);
      longint          a00, a11, a22, a33, a01, a10, a02, a20, a12, a21;
      longint          sums[4];
      longint          best;
      logic [1:0]      sel;
      longint unsigned r;
      logic [WORD_WIDTH-1:0] h;
      rsp_type         q;
      a00 = longint'(m.m00); a11 = longint'(m.m11);
      a22 = longint'(m.m22); a33 = longint'(m.m33);
      a01 = longint'(m.m01); a10 = longint'(m.m10);
      a02 = longint'(m.m02); a20 = longint'(m.m20);
      a12 = longint'(m.m12); a21 = longint'(m.m21);
      sums[0] = a00 + a11 + a22 + a33;
      sums[1] = a00 - a11 - a22 + a33;
      sums[2] = -a00 + a11 - a22 + a33;
      sums[3] = -a00 - a11 + a22 + a33;
      best = sums[0];
      sel  = SEL_W;
      for (int i = 1; i < 4; i++) begin
         if (sums[i] > best) begin
            best = sums[i];
            sel  = 2'(i);
         end
      end
      q = '0;
      if (best <= 0) begin
         q.degenerate = 1'b1;
         return q;
      end
      r = fixed_sqrt(best);
      h = ((r + 1) >> 1) > POS_LIM ? WORD_WIDTH'(POS_LIM) : WORD_WIDTH'((r + 1) >> 1);
      case (sel)
         SEL_W: begin
            q.quat_w = h;
            q.quat_x = scaled_part(a12 - a21, r);
            q.quat_y = scaled_part(a20 - a02, r);
            q.quat_z = scaled_part(a01 - a10, r);
         end
         SEL_X: begin
            q.quat_w = scaled_part(a12 - a21, r);
            q.quat_x = h;
            q.quat_y = scaled_part(a01 + a10, r);
            q.quat_z = scaled_part(a02 + a20, r);
         end
         SEL_Y: begin
            q.quat_w = scaled_part(a20 - a02, r);
            q.quat_x = scaled_part(a01 + a10, r);
            q.quat_y = h;
            q.quat_z = scaled_part(a12 + a21, r);
         end
         default: begin
            q.quat_w = scaled_part(a01 - a10, r);
            q.quat_x = scaled_part(a02 + a20, r);
            q.quat_y = scaled_part(a12 + a21, r);
            q.quat_z = h;
         end
      endcase
      return q;
   endfunction

   function automatic req_type mk(int d0, int d1, int d2, int d3,
                                  int o01 = 0, int o10 = 0, int o02 = 0,
                                  int o20 = 0, int o12 = 0, int o21 = 0);
      req_type m;
      m.m00 = WORD_WIDTH'(d0); m.m11 = WORD_WIDTH'(d1);
      m.m22 = WORD_WIDTH'(d2); m.m33 = WORD_WIDTH'(d3);
      m.m01 = WORD_WIDTH'(o01); m.m10 = WORD_WIDTH'(o10);
      m.m02 = WORD_WIDTH'(o02); m.m20 = WORD_WIDTH'(o20);
      m.m12 = WORD_WIDTH'(o12); m.m21 = WORD_WIDTH'(o21);
      return m;
   endfunction

   function automatic rsp_type quat(int w, int x, int y, int z, bit deg);
      rsp_type q;
      q.quat_w = WORD_WIDTH'(w); q.quat_x = WORD_WIDTH'(x);
      q.quat_y = WORD_WIDTH'(y); q.quat_z = WORD_WIDTH'(z);
      q.degenerate = deg;
      return q;
   endfunction

   function automatic int rand_word();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? -524288 : 524287;
         1:       return int'($urandom_range(0, 131072)) - 65536;
         2:       return int'($urandom_range(0, 2048)) - 1024;
         default: return int'($urandom_range(0, 1048575)) - 524288;
      endcase
   endfunction

   // mostly near-rotation shapes so each branch is picked often
   function automatic req_type rand_matrix();
      req_type m;
      int      pick;
      m = mk(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
             rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      if ($urandom_range(0, 99) < 60) begin
         pick = int'($urandom_range(0, 3));
         m.m33 = WORD_WIDTH'(65536);
         m.m00 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         m.m11 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         m.m22 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         if (pick == 1) m.m00 = WORD_WIDTH'(65536 - int'($urandom_range(0, 4096)));
         if (pick == 2) m.m11 = WORD_WIDTH'(65536 - int'($urandom_range(0, 4096)));
         if (pick == 3) m.m22 = WORD_WIDTH'(65536 - int'($urandom_range(0, 4096)));
         m.m01 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         m.m10 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         m.m02 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         m.m20 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         m.m12 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
         m.m21 = WORD_WIDTH'(int'($urandom_range(0, 131072)) - 65536);
      end
      return m;
   endfunction

   task automatic send_matrix(req_type m, rsp_type q);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_quats.push_back(q);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_quats.size() == 0) begin
            $error("unexpected result beat");
            error_count++;
         end else begin
            want = pending_quats.pop_front();
            if (rsp_data.quat_w !== want.quat_w) begin
               $error("quat_w exp %0d got %0d", want.quat_w, rsp_data.quat_w);
               error_count++;
            end
            if (rsp_data.quat_x !== want.quat_x) begin
               $error("quat_x exp %0d got %0d", want.quat_x, rsp_data.quat_x);
               error_count++;
            end
            if (rsp_data.quat_y !== want.quat_y) begin
               $error("quat_y exp %0d got %0d", want.quat_y, rsp_data.quat_y);
               error_count++;
            end
            if (rsp_data.quat_z !== want.quat_z) begin
               $error("quat_z exp %0d got %0d", want.quat_z, rsp_data.quat_z);
               error_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate exp %0d got %0d", want.degenerate,
                      rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   initial begin
      vector_type vectors[$];
      vector_type v;
      int         wait_cycles;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      // identity, zero, negative scale, branch choice, ties, extremes
      v.has_quat = 1'b1;
      v.matrix = mk(65536, 65536, 65536, 65536);
      v.quat = quat(65536, 0, 0, 0, 1'b0); vectors.push_back(v);
      v.matrix = mk(0, 0, 0, 0);
      v.quat = quat(0, 0, 0, 0, 1'b1); vectors.push_back(v);
      v.matrix = mk(0, 0, 0, -65536);
      v.quat = quat(0, 0, 0, 0, 1'b1); vectors.push_back(v);
      v.matrix = mk(-524288, -524288, -524288, -524288, -524288, -524288,
                    -524288, -524288, -524288, -524288);
      v.quat = quat(0, 0, 0, 0, 1'b1); vectors.push_back(v);
      v.has_quat = 1'b0;
      v.matrix = mk(65536, -65536, -65536, 65536); vectors.push_back(v);
      v.matrix = mk(-65536, 65536, -65536, 65536); vectors.push_back(v);
      v.matrix = mk(-65536, -65536, 65536, 65536); vectors.push_back(v);
      v.matrix = mk(0, 0, 0, 65536, 1000, -1000, 2000, -3000, 4000, 5000);
      vectors.push_back(v);
      v.matrix = mk(65536, 65536, 0, 0, 1, 2, 3, 4, 5, 6); vectors.push_back(v);
      v.matrix = mk(0, 0, 0, 1, 524287, -524288, 524287, 524287, -524288,
                    524287);
      vectors.push_back(v);
      v.matrix = mk(0, 0, 0, 1, -524288, 524287, -524288, -524288, 524287,
                    -524288);
      vectors.push_back(v);
      v.matrix = mk(524287, 524287, 524287, 524287, -524288, 524287, 524287,
                    -524288, 524287, -524288);
      vectors.push_back(v);
      v.matrix = mk(524287, -524288, -524288, 524287, 524287, 524287, 524287,
                    524287, 524287, 524287);
      vectors.push_back(v);
      v.matrix = mk(-524288, -524288, 524287, 524287, -1, -1, -1, -1, -1, -1);
      vectors.push_back(v);
      v.matrix = mk(1, 0, 0, 0, 3, 0, 0, 0, 0, 0); vectors.push_back(v);
      v.matrix = mk(0, 0, 0, 2, 0, 0, 0, 0, 1, 0); vectors.push_back(v);
      v.matrix = mk(0, 0, 0, 65536, 0, 0, 0, 0, 0, 131073); vectors.push_back(v);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i])
         send_matrix(vectors[i].matrix, vectors[i].has_quat ? vectors[i].quat
                                        : matrix_to_quat(vectors[i].matrix));
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 58 : 0;
         repeat (480) begin
            v.matrix = rand_matrix();
            send_matrix(v.matrix, matrix_to_quat(v.matrix));
         end
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_quats.size() != 0 && wait_cycles < 20 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY) @(posedge clock);
      if (error_count == 0 && pending_quats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (pending_quats.size() != 0)
            $error("%0d results never arrived", pending_quats.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
sv/rmq_pkg.sv
sv/rotation_matrix_to_quaternion_top.sv
test/tb_rotation_matrix_to_quaternion_top.sv
